// ===== rtl/prrs_pkg.sv =====
//------------------------------------------------------------------------------
// prrs_pkg
// shared types and constants of the per-flow round robin packet scheduler
//------------------------------------------------------------------------------
package prrs_pkg;

    localparam int NUM_FLOWS   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int FLOW_W      = $clog2(NUM_FLOWS);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ORDER_DEPTH = NUM_FLOWS * QUEUE_DEPTH;
    localparam int OPTR_W      = $clog2(ORDER_DEPTH);
    localparam int RPT_W       = $clog2(NUM_FLOWS + 1);
    localparam int QCAP        = 4;
    localparam int QCNT_W      = $clog2(QCAP + 1);
    localparam int QIDX_W      = $clog2(QCAP);

    typedef enum logic [0:0] {
        ACT_ENQ  = 1'b0,
        ACT_DONE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        EV_START  = 2'd0,
        EV_DEPART = 2'd1,
        EV_DROP   = 2'd2,
        EV_STRAY  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_EMIT1 = 2'd2,
        ST_EMIT2 = 2'd3
    } state_t;

    typedef struct packed {
        action_t             action;
        logic [FLOW_W-1:0]   flow;
        logic [TAG_BITS-1:0] tag;
        logic                swift;
    } item_t;

endpackage

// ===== rtl/prrs_front.sv =====
//------------------------------------------------------------------------------
// prrs_front
// input skid queue: accepts items and holds them until the back end is free
//------------------------------------------------------------------------------
module prrs_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  prrs_pkg::item_t         in_item,
    output logic                    q_valid,
    input  logic                    q_pop,
    output prrs_pkg::item_t         q_item
);

    prrs_pkg::item_t                 mem_reg [prrs_pkg::QCAP];
    logic [prrs_pkg::QIDX_W-1:0]     wr_reg, wr_next;
    logic [prrs_pkg::QIDX_W-1:0]     rd_reg, rd_next;
    logic [prrs_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            push;
    logic                            pop;

    assign in_ready = (cnt_reg != prrs_pkg::QCNT_W'(prrs_pkg::QCAP));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + prrs_pkg::QCNT_W'(push) - prrs_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/prrs_back.sv =====
//------------------------------------------------------------------------------
// prrs_back
// scheduler core: per-flow queues, arrival order, selection and result output
//------------------------------------------------------------------------------
module prrs_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            sched_mode,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  prrs_pkg::item_t                 q_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_event_kind,
    output logic [prrs_pkg::FLOW_W-1:0]     m_out_flow,
    output logic [prrs_pkg::TAG_BITS-1:0]   m_out_tag,
    output logic                            m_out_swift,
    output logic                            m_request_more,
    output logic                            m_last,
    output logic                            busy
);

    localparam int NF = prrs_pkg::NUM_FLOWS;
    localparam int FW = prrs_pkg::FLOW_W;
    localparam int TW = prrs_pkg::TAG_BITS;
    localparam int PW = TW + 1;

    logic [PW-1:0]                  pstore [prrs_pkg::ORDER_DEPTH];
    logic [FW-1:0]                  order_mem [prrs_pkg::ORDER_DEPTH];
    logic [prrs_pkg::QPTR_W-1:0]    head_reg [NF];
    logic [prrs_pkg::QPTR_W-1:0]    tail_reg [NF];
    logic [prrs_pkg::FILL_W-1:0]    fill_reg [NF];
    logic [NF-1:0]                  seen_reg;
    logic [prrs_pkg::RPT_W-1:0]     resume_reg;
    logic [prrs_pkg::OPTR_W-1:0]    ohead_reg, otail_reg;
    logic [prrs_pkg::OPTR_W:0]      total_reg;
    logic                           busy_reg;
    logic [FW-1:0]                  sflow_reg;
    logic [TW-1:0]                  stag_reg;
    logic                           sswift_reg;

    prrs_pkg::state_t               state_reg, state_next;
    prrs_pkg::item_t                cur_reg;
    logic [PW-1:0]                  prd_reg;
    logic [FW-1:0]                  ord_reg;
    logic                           start_reg;
    logic [FW-1:0]                  pflow_reg;
    logic [1:0]                     e1_kind_reg;
    logic [FW-1:0]                  e1_flow_reg;
    logic [TW-1:0]                  e1_tag_reg;
    logic                           e1_swift_reg;
    logic                           e1_req_reg;

    // fair pick over seen flows with a queued packet
    logic [NF-1:0]                  elig;
    logic [FW-1:0]                  fair_flow;
    logic                           fair_ok;
    logic [FW-1:0]                  fstart;
    logic [prrs_pkg::RPT_W-1:0]     resume_after;
    logic [FW-1:0]                  pick_flow;
    logic                           pick_ok;
    logic                           fifo_ok;
    logic                           use_fair;
    logic [FW-1:0]                  cur_flow;
    logic                           drop;
    logic                           enq_ok;
    logic                           will_start;

    always_comb begin
        for (int i = 0; i < NF; i++) begin
            elig[i] = seen_reg[i] && (fill_reg[i] != '0);
        end
    end

    function automatic logic [prrs_pkg::RPT_W-1:0] first_from(
        input logic [NF-1:0] v, input logic [prrs_pkg::RPT_W-1:0] f);
        logic [prrs_pkg::RPT_W-1:0] r;
        r = prrs_pkg::RPT_W'(NF);
        for (int g = NF - 1; g >= 0; g--) begin
            if (v[g] && (prrs_pkg::RPT_W'(g) >= f)) begin
                r = prrs_pkg::RPT_W'(g);
            end
        end
        return r;
    endfunction

    logic [prrs_pkg::RPT_W-1:0] sf0;
    logic [prrs_pkg::RPT_W-1:0] hi_pick;
    logic [prrs_pkg::RPT_W-1:0] lo_pick;

    always_comb begin
        sf0 = first_from(seen_reg, '0);
        if (resume_reg < prrs_pkg::RPT_W'(NF)) begin
            fstart = resume_reg[FW-1:0];
        end else if (sf0 < prrs_pkg::RPT_W'(NF)) begin
            fstart = sf0[FW-1:0];
        end else begin
            fstart = '0;
        end
        hi_pick = first_from(elig, {1'b0, fstart});
        lo_pick = first_from(elig, '0);
        fair_ok = (elig != '0);
        fair_flow = (hi_pick < prrs_pkg::RPT_W'(NF)) ? hi_pick[FW-1:0] : lo_pick[FW-1:0];
        resume_after = first_from(seen_reg, prrs_pkg::RPT_W'(fair_flow) + 1'b1);
    end

    always_comb begin
        fifo_ok   = sched_mode && (fill_reg[ord_reg] != '0);
        use_fair  = !fifo_ok;
        pick_flow = fifo_ok ? ord_reg : fair_flow;
        pick_ok   = (total_reg != '0) && (fifo_ok || fair_ok);
    end

    assign cur_flow = cur_reg.flow;
    assign drop     = (fill_reg[cur_flow] == prrs_pkg::FILL_W'(prrs_pkg::QUEUE_DEPTH));
    assign enq_ok   = (cur_reg.action == prrs_pkg::ACT_ENQ) && !drop;

    // state machine: IDLE takes an item, READ does the memory reads and updates, EMIT1/EMIT2 present events
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            prrs_pkg::ST_IDLE:  if (q_valid) state_next = prrs_pkg::ST_READ;
            prrs_pkg::ST_READ:  state_next = prrs_pkg::ST_EMIT1;
            prrs_pkg::ST_EMIT1: begin
                if (e1_kind_reg == prrs_pkg::EV_DEPART && start_reg) begin
                    if (m_ready) state_next = prrs_pkg::ST_EMIT2;
                end else if (e1_kind_reg == prrs_pkg::EV_START && !start_reg) begin
                    state_next = prrs_pkg::ST_IDLE;
                end else if (m_ready) begin
                    state_next = prrs_pkg::ST_IDLE;
                end
            end
            prrs_pkg::ST_EMIT2: if (m_ready) state_next = prrs_pkg::ST_IDLE;
            default: state_next = prrs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop          = (state_reg == prrs_pkg::ST_IDLE) && q_valid;
        m_valid        = 1'b0;
        m_event_kind   = e1_kind_reg;
        m_out_flow     = e1_flow_reg;
        m_out_tag      = e1_tag_reg;
        m_out_swift    = e1_swift_reg;
        m_request_more = e1_req_reg;
        m_last         = 1'b1;
        unique case (state_reg)
            prrs_pkg::ST_EMIT1: begin
                m_valid = !(e1_kind_reg == prrs_pkg::EV_START && !start_reg);
                m_last  = !(e1_kind_reg == prrs_pkg::EV_DEPART && start_reg);
            end
            prrs_pkg::ST_EMIT2: begin
                m_valid        = 1'b1;
                m_event_kind   = prrs_pkg::EV_START;
                m_out_flow     = pflow_reg;
                m_out_tag      = prd_reg[PW-1:1];
                m_out_swift    = prd_reg[0];
                m_request_more = 1'b0;
            end
            default: ;
        endcase
    end

    assign busy = busy_reg;

    // read at item take: order head; at READ: packet word of the enqueued or picked flow
    assign will_start = (state_reg == prrs_pkg::ST_READ) &&
                        ((cur_reg.action == prrs_pkg::ACT_ENQ) ? (enq_ok && !busy_reg)
                                                               : (busy_reg && pick_ok));

    logic [FW-1:0]                rd_flow;
    logic [prrs_pkg::QPTR_W-1:0]  rd_head;
    logic                         enq_idle_start;

    // enqueue to an idle link starts the new packet directly when it is the only one
    assign enq_idle_start = enq_ok && !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= prrs_pkg::ST_IDLE;
            seen_reg   <= '0;
            resume_reg <= prrs_pkg::RPT_W'(NF);
            ohead_reg  <= '0;
            otail_reg  <= '0;
            total_reg  <= '0;
            busy_reg   <= 1'b0;
            start_reg  <= 1'b0;
            for (int i = 0; i < NF; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == prrs_pkg::ST_READ) begin
                start_reg <= will_start;
                if (cur_reg.action == prrs_pkg::ACT_ENQ) begin
                    if (enq_ok) begin
                        seen_reg[cur_flow] <= 1'b1;
                        tail_reg[cur_flow] <= tail_reg[cur_flow] + 1'b1;
                        otail_reg <= otail_reg + 1'b1;
                        if (!busy_reg) begin
                            // idle link means all queues were empty: serve it now
                            head_reg[cur_flow] <= head_reg[cur_flow] + 1'b1;
                            ohead_reg <= ohead_reg + 1'b1;
                            busy_reg  <= 1'b1;
                            if (!sched_mode) begin
                                resume_reg <= first_from(seen_reg | (NF'(1) << cur_flow),
                                    prrs_pkg::RPT_W'(cur_flow) + 1'b1);
                            end
                        end else begin
                            fill_reg[cur_flow] <= fill_reg[cur_flow] + 1'b1;
                            total_reg <= total_reg + 1'b1;
                        end
                    end
                end else if (busy_reg) begin
                    busy_reg <= pick_ok;
                    if (total_reg != '0) begin
                        ohead_reg <= ohead_reg + 1'b1;
                    end
                    if (pick_ok) begin
                        head_reg[pick_flow] <= head_reg[pick_flow] + 1'b1;
                        fill_reg[pick_flow] <= fill_reg[pick_flow] - 1'b1;
                        total_reg <= total_reg - 1'b1;
                        if (use_fair) begin
                            resume_reg <= resume_after;
                        end
                    end
                end
            end
        end
    end

    assign rd_flow = (cur_reg.action == prrs_pkg::ACT_ENQ) ? cur_flow : pick_flow;
    assign rd_head = head_reg[rd_flow];

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
            ord_reg <= order_mem[ohead_reg];
        end
        if (state_reg == prrs_pkg::ST_READ) begin
            prd_reg   <= pstore[{rd_flow, rd_head}];
            pflow_reg <= rd_flow;
            if (enq_ok) begin
                pstore[{cur_flow, tail_reg[cur_flow]}] <= {cur_reg.tag, cur_reg.swift};
                order_mem[otail_reg] <= cur_flow;
            end
            if (cur_reg.action == prrs_pkg::ACT_ENQ) begin
                e1_kind_reg  <= drop ? prrs_pkg::EV_DROP : prrs_pkg::EV_START;
                e1_flow_reg  <= cur_flow;
                e1_tag_reg   <= cur_reg.tag;
                e1_swift_reg <= cur_reg.swift;
                e1_req_reg   <= 1'b0;
            end else if (busy_reg) begin
                e1_kind_reg  <= prrs_pkg::EV_DEPART;
                e1_flow_reg  <= sflow_reg;
                e1_tag_reg   <= stag_reg;
                e1_swift_reg <= sswift_reg;
                e1_req_reg   <= sswift_reg;
            end else begin
                e1_kind_reg  <= prrs_pkg::EV_STRAY;
                e1_flow_reg  <= '0;
                e1_tag_reg   <= '0;
                e1_swift_reg <= 1'b0;
                e1_req_reg   <= 1'b0;
            end
            if (enq_idle_start) begin
                sflow_reg  <= cur_flow;
                stag_reg   <= cur_reg.tag;
                sswift_reg <= cur_reg.swift;
            end
        end
        if (state_reg == prrs_pkg::ST_EMIT1 && e1_kind_reg == prrs_pkg::EV_DEPART
            && start_reg) begin
            sflow_reg  <= pflow_reg;
            stag_reg   <= prd_reg[PW-1:1];
            sswift_reg <= prd_reg[0];
        end
    end

endmodule

// ===== rtl/per_flow_round_robin_packet_scheduler_top.sv =====
// flow: an item is taken in IDLE, read and updated in READ, and its event, if
// any, is emitted in EMIT1, with a follow-on start in EMIT2; the core takes no
// new item until its events are accepted, while the front queue keeps taking items
// reset: synchronous active low; queues empty, link idle, fair mode
//------------------------------------------------------------------------------
// per_flow_round_robin_packet_scheduler_top
// per-flow round robin / global fifo packet scheduler for an output link
//------------------------------------------------------------------------------
module per_flow_round_robin_packet_scheduler_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [3:0]                      s_flow_index,
    input  logic [15:0]                     s_packet_tag,
    input  logic                            s_is_swift,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_event_kind,
    output logic [3:0]                      m_out_flow,
    output logic [15:0]                     m_out_tag,
    output logic                            m_out_swift,
    output logic                            m_request_more,
    output logic                            m_last
);

    logic             mode_reg;
    prrs_pkg::item_t  in_item;
    prrs_pkg::item_t  q_item;
    logic             q_valid;
    logic             q_pop;
    logic             busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    assign in_item.action = prrs_pkg::action_t'(s_action);
    assign in_item.flow   = s_flow_index;
    assign in_item.tag    = s_packet_tag;
    assign in_item.swift  = s_is_swift;

    prrs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    prrs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sched_mode     (mode_reg),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_out_flow     (m_out_flow),
        .m_out_tag      (m_out_tag),
        .m_out_swift    (m_out_swift),
        .m_request_more (m_request_more),
        .m_last         (m_last),
        .busy           (busy)
    );

    a_req_only_depart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_request_more) |-> (m_event_kind == prrs_pkg::EV_DEPART))
        else $error("request_more outside departure");

    a_stray_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind == prrs_pkg::EV_STRAY) |->
        (m_out_flow == '0 && m_out_tag == '0 && !busy))
        else $error("stray completion with payload or busy link");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind == prrs_pkg::EV_START) |-> busy)
        else $error("service start without busy link");

endmodule

// ===== tb/prrs_checker.sv =====
//------------------------------------------------------------------------------
// prrs_checker
// watches the config, packet and event channels of the packet scheduler,
// predicts each event from its own copy of the queues and compares in order
//------------------------------------------------------------------------------
module prrs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_action,
    input  logic [3:0]  s_flow_index,
    input  logic [15:0] s_packet_tag,
    input  logic        s_is_swift,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_event_kind,
    input  logic [3:0]  m_out_flow,
    input  logic [15:0] m_out_tag,
    input  logic        m_out_swift,
    input  logic        m_request_more,
    input  logic        m_last,
    output int          fail_count,
    output int          pending_events
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        prrs_pkg::event_t              kind;
        logic [prrs_pkg::FLOW_W-1:0]   flow;
        logic [prrs_pkg::TAG_BITS-1:0] tag;
        logic                          swift;
        logic                          req;
        logic                          last;
    } sched_event_t;

    sched_event_t event_q[$];

    logic [prrs_pkg::TAG_BITS:0]     slot_word [prrs_pkg::NUM_FLOWS][prrs_pkg::QUEUE_DEPTH];
    int                              head_ptr [prrs_pkg::NUM_FLOWS];
    int                              tail_ptr [prrs_pkg::NUM_FLOWS];
    int                              fill_cnt [prrs_pkg::NUM_FLOWS];
    logic [prrs_pkg::NUM_FLOWS-1:0]  seen_mask;
    int                              rr_resume;
    logic [prrs_pkg::FLOW_W-1:0]     order_fifo [prrs_pkg::ORDER_DEPTH];
    int                              ord_head, ord_tail, total_queued;
    logic                            busy, fifo_mode;
    sched_event_t                    on_link;

    function automatic int first_seen_from(int f);
        for (int g = f; g < prrs_pkg::NUM_FLOWS; g++) if (seen_mask[g]) return g;
        return prrs_pkg::NUM_FLOWS;
    endfunction

    function automatic int pick_fair();
        int start;
        int g;
        start = (rr_resume < prrs_pkg::NUM_FLOWS) ? rr_resume : first_seen_from(0);
        if (start >= prrs_pkg::NUM_FLOWS) start = 0;
        for (int i = 0; i < prrs_pkg::NUM_FLOWS; i++) begin
            g = (start + i) % prrs_pkg::NUM_FLOWS;
            if (seen_mask[g] && fill_cnt[g] > 0) begin
                rr_resume = first_seen_from(g + 1);
                return g;
            end
        end
        return prrs_pkg::NUM_FLOWS;
    endfunction

    // chooses the next packet, pushes its start event
    function automatic void launch_next();
        int f;
        int cand;
        logic [prrs_pkg::TAG_BITS:0] w;
        sched_event_t e;
        f = prrs_pkg::NUM_FLOWS;
        if (total_queued == 0) return;
        if (fifo_mode) begin
            cand = int'(order_fifo[ord_head]);
            if (fill_cnt[cand] > 0) f = cand;
        end
        ord_head = (ord_head + 1) % prrs_pkg::ORDER_DEPTH;
        if (f >= prrs_pkg::NUM_FLOWS) f = pick_fair();
        if (f >= prrs_pkg::NUM_FLOWS) return;
        w = slot_word[f][head_ptr[f]];
        head_ptr[f] = (head_ptr[f] + 1) % prrs_pkg::QUEUE_DEPTH;
        fill_cnt[f]--;
        total_queued--;
        e.kind  = prrs_pkg::EV_START;
        e.flow  = prrs_pkg::FLOW_W'(f);
        e.tag   = w[prrs_pkg::TAG_BITS:1];
        e.swift = w[0];
        e.req   = 1'b0;
        e.last  = 1'b1;
        on_link = e;
        busy    = 1'b1;
        event_q.push_back(e);
    endfunction

    function automatic void predict_item(logic act, logic [3:0] f, logic [15:0] tag,
                                         logic sw);
        sched_event_t e;
        e.flow = f; e.tag = tag; e.swift = sw; e.req = 1'b0; e.last = 1'b1;
        if (act == prrs_pkg::ACT_ENQ) begin
            if (fill_cnt[f] >= prrs_pkg::QUEUE_DEPTH) begin
                e.kind = prrs_pkg::EV_DROP;
                event_q.push_back(e);
                return;
            end
            seen_mask[f] = 1'b1;
            slot_word[f][tail_ptr[f]] = {tag, sw};
            tail_ptr[f] = (tail_ptr[f] + 1) % prrs_pkg::QUEUE_DEPTH;
            fill_cnt[f]++;
            total_queued++;
            order_fifo[ord_tail] = f;
            ord_tail = (ord_tail + 1) % prrs_pkg::ORDER_DEPTH;
            if (!busy) launch_next();
        end else if (!busy) begin
            e = '0;
            e.kind = prrs_pkg::EV_STRAY;
            e.last = 1'b1;
            event_q.push_back(e);
        end else begin
            int n;
            e = on_link;
            e.kind = prrs_pkg::EV_DEPART;
            e.req  = on_link.swift;
            busy = 1'b0;
            on_link = '0;
            n = event_q.size();
            event_q.push_back(e);
            launch_next();
            if (event_q.size() > n + 1) event_q[n].last = 1'b0;
        end
    endfunction

    sched_event_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            event_q.delete();
            for (int f = 0; f < prrs_pkg::NUM_FLOWS; f++) begin
                head_ptr[f] = 0; tail_ptr[f] = 0; fill_cnt[f] = 0;
            end
            seen_mask = '0; rr_resume = prrs_pkg::NUM_FLOWS;
            ord_head = 0; ord_tail = 0; total_queued = 0;
            busy = 1'b0; on_link = '0; fifo_mode = 1'b0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {prrs_pkg::event_t'(m_event_kind), m_out_flow, m_out_tag,
                       m_out_swift, m_request_more, m_last};
                if (event_q.size() == 0) begin
                    $error("unexpected event kind %0d flow %0d", m_event_kind, m_out_flow);
                    fail_count++;
                end else begin
                    want = event_q.pop_front();
                    if (got.kind != want.kind) begin
                        $error("event_kind exp %0d got %0d", want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.flow != want.flow) begin
                        $error("out_flow exp %0d got %0d", want.flow, got.flow);
                        fail_count++;
                    end
                    if (got.tag != want.tag) begin
                        $error("out_tag exp %h got %h", want.tag, got.tag);
                        fail_count++;
                    end
                    if (got.swift != want.swift) begin
                        $error("out_swift exp %0d got %0d", want.swift, got.swift);
                        fail_count++;
                    end
                    if (got.req != want.req) begin
                        $error("request_more exp %0d got %0d", want.req, got.req);
                        fail_count++;
                    end
                    if (got.last != want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) fifo_mode = cfg_data;
            if (s_valid && s_ready)
                predict_item(s_action, s_flow_index, s_packet_tag, s_is_swift);
        end
        pending_events = event_q.size();
    end
endmodule

// ===== tb/tb.sv =====
//------------------------------------------------------------------------------
// tb
// random and directed stimulus for the packet scheduler; fair and fifo
// modes, full queues, stray completions, receiver backpressure
//------------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0, cfg_data = 1'b0;
    logic        cfg_ready;
    logic        s_valid = 1'b0, s_action = 1'b0, s_is_swift = 1'b0;
    logic [3:0]  s_flow_index = '0;
    logic [15:0] s_packet_tag = '0;
    logic        s_ready;
    logic        m_valid, m_out_swift, m_request_more, m_last;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_kind;
    logic [3:0]  m_out_flow;
    logic [15:0] m_out_tag;
    int          fail_count, pending_events;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;
    int          gap_max = 3;

    always #5 aclk = ~aclk;

    per_flow_round_robin_packet_scheduler_top i_dut (.*);
    prrs_checker i_chk (.*);

    // receiver stall pattern
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off) m_ready <= 1'b0;
            else if ($urandom_range(0, 9) < 3) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= 1'b1;
        end
    end

    // valid stays up between back-to-back items and drops only in a gap
    task automatic send_item(logic act, logic [3:0] f, logic [15:0] tag, logic sw);
        if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge aclk);
        end
        s_valid <= 1'b1; s_action <= act; s_flow_index <= f;
        s_packet_tag <= tag; s_is_swift <= sw;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_mode(logic m);
        s_valid <= 1'b0;
        wait (pending_events == 0);
        repeat (12) @(negedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1; cfg_data <= m;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic enq(logic [3:0] f, logic [15:0] tag, logic sw);
        send_item(prrs_pkg::ACT_ENQ, f, tag, sw);
    endtask

    task automatic done();
        send_item(prrs_pkg::ACT_DONE, 4'($urandom), 16'($urandom), 1'($urandom));
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        // directed: stray, extremes, fair rotation, full queue
        done();
        enq(4'd0, 16'h0000, 1'b0);
        enq(4'd15, 16'hffff, 1'b1);
        enq(4'd7, 16'h5a5a, 1'b1);
        done(); done(); done(); done();
        gap_max = 0;
        for (int i = 0; i < 17; i++) enq(4'd3, 16'(i * 16'h0f0f), i[0]);
        gap_max = 3;
        write_mode(1'b1);
        repeat (17) done();
        for (int p = 0; p < 4; p++) begin
            write_mode(p[0]);
            // long receiver hold-off while the sender keeps going
            if (p == 1) fork
                begin
                    hold_off = 1'b1;
                    repeat (300) @(negedge aclk);
                    hold_off = 1'b0;
                end
            join_none
            for (int i = 0; i < 120; i++) begin
                if ($urandom_range(0, 9) < 6)
                    enq(p == 3 ? 4'($urandom_range(0, 2)) : 4'($urandom),
                        16'($urandom), 1'($urandom));
                else done();
            end
            while (i_chk.busy == 1'b1 || 0) begin
                done();
                if (pending_events == 0 && $urandom_range(0, 40) == 0) break;
            end
        end
        repeat (20) done();
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        wait (pending_events == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/prrs_pkg.sv
rtl/prrs_front.sv
rtl/prrs_back.sv
rtl/per_flow_round_robin_packet_scheduler_top.sv
tb/prrs_checker.sv
tb/tb.sv
